/* rtl/stbs_pkg.sv */
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants of the sorted table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

  localparam int KeyW   = 32;
  localparam int IndexW = 10;
  localparam int PosW   = 10;
  localparam int CountW = 11;
  localparam int KindW  = 2;

  typedef logic [KindW-1:0] stbs_kind_t;

  localparam stbs_kind_t CMD_WRITE  = 2'd0;
  localparam stbs_kind_t CMD_SEARCH = 2'd1;
  localparam stbs_kind_t CMD_MISS   = 2'd2;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] position;
  } stbs_result_t;

endpackage

`default_nettype wire

/* rtl/stbs_fifo.sv */
// ----------------------------------------------------------------------------
// stbs_fifo
// Small register queue with full and empty flags and a show-ahead head.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = data_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      data_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/stbs_front.sv */
// ----------------------------------------------------------------------------
// stbs_front
// Accepts request items, sorts them into table writes, searches and searches
// over an empty table; it queues all but out-of-range writes for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_front #(
  parameter int TABLE_DEPTH = 1024,
  parameter int IDX_W       = 10
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          in_req_type,
  input  wire logic [stbs_pkg::IndexW-1:0]   in_entry_index,
  input  wire logic signed [stbs_pkg::KeyW-1:0] in_entry_value,
  input  wire logic signed [stbs_pkg::KeyW-1:0] in_search_key,
  input  wire logic [stbs_pkg::CountW-1:0]   cfg_count,
  input  wire logic                          q_pop,
  output logic                               q_empty,
  output stbs_pkg::stbs_kind_t               q_kind,
  output logic [IDX_W-1:0]                   q_idx,
  output logic [stbs_pkg::KeyW-1:0]          q_val
);

  localparam int QW = stbs_pkg::KindW + IDX_W + stbs_pkg::KeyW;

  stbs_pkg::stbs_kind_t       kind;
  logic [IDX_W-1:0]           idx;
  logic [stbs_pkg::KeyW-1:0]  val;
  logic [31:0]                count_sat;
  logic                       keep;
  logic [QW-1:0]              q_wdata, q_rdata;

  // The search range ends at the last loaded entry, the count held to the table depth.
  assign count_sat = (32'(cfg_count) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                           : 32'(cfg_count);

  always_comb begin
    keep = 1'b1;
    if (!in_req_type) begin
      kind = stbs_pkg::CMD_WRITE;
      idx  = IDX_W'(in_entry_index);
      val  = in_entry_value;
      keep = (32'(in_entry_index) < 32'(TABLE_DEPTH));
    end else if (cfg_count == '0) begin
      kind = stbs_pkg::CMD_MISS;
      idx  = '0;
      val  = in_search_key;
    end else begin
      kind = stbs_pkg::CMD_SEARCH;
      idx  = IDX_W'(count_sat - 32'd1);
      val  = in_search_key;
    end
  end

  assign q_wdata = {kind, idx, val};

  stbs_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (push && keep),
    .wr_data(q_wdata),
    .rd_en  (q_pop),
    .rd_data(q_rdata),
    .full   (full),
    .empty  (q_empty)
  );

  assign {q_kind, q_idx, q_val} = q_rdata;

endmodule

`default_nettype wire

/* rtl/stbs_back.sv */
// ----------------------------------------------------------------------------
// stbs_back
// Holds the table memory, applies writes and runs each search as a
// sequence of memory reads, then queues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_back #(
  parameter int TABLE_DEPTH = 1024,
  parameter int IDX_W       = 10
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  output logic                            q_pop,
  input  wire logic                       q_empty,
  input  wire stbs_pkg::stbs_kind_t       q_kind,
  input  wire logic [IDX_W-1:0]           q_idx,
  input  wire logic [stbs_pkg::KeyW-1:0]  q_val,
  input  wire logic                       pop,
  output logic                            empty,
  output stbs_pkg::stbs_result_t          res_head
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LO   = 3'd1;
  localparam logic [2:0] ST_HI   = 3'd2;
  localparam logic [2:0] ST_MID  = 3'd3;
  localparam logic [2:0] ST_EVAL = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam int RW = $bits(stbs_pkg::stbs_result_t);

  logic [stbs_pkg::KeyW-1:0]        tbl_mem [TABLE_DEPTH];
  logic signed [stbs_pkg::KeyW-1:0] rd_data_r;
  logic [IDX_W-1:0]                 rd_addr;
  logic                             mem_we;

  logic [2:0]                       state_r, state_nxt;
  logic [IDX_W-1:0]                 low_r, low_nxt;
  logic [IDX_W-1:0]                 high_r, high_nxt;
  logic [IDX_W-1:0]                 mid_r, mid_nxt;
  logic signed [stbs_pkg::KeyW-1:0] key_r, key_nxt;
  logic                             found_r, found_nxt;
  logic [IDX_W-1:0]                 pos_r, pos_nxt;

  logic                             res_push, res_full;
  stbs_pkg::stbs_result_t           res_wdata;
  logic [RW-1:0]                    res_rdata;

  always_comb begin
    state_nxt = state_r;
    low_nxt   = low_r;
    high_nxt  = high_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    rd_addr   = low_r;
    mem_we    = 1'b0;
    q_pop     = 1'b0;
    res_push  = 1'b0;
    res_wdata.found    = found_r;
    res_wdata.position = stbs_pkg::PosW'(pos_r);
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_kind)
            stbs_pkg::CMD_WRITE: begin
              mem_we = 1'b1;
              q_pop  = 1'b1;
            end
            stbs_pkg::CMD_MISS: begin
              res_wdata.found    = 1'b0;
              res_wdata.position = '0;
              if (!res_full) begin
                res_push = 1'b1;
                q_pop    = 1'b1;
              end
            end
            stbs_pkg::CMD_SEARCH: begin
              q_pop     = 1'b1;
              key_nxt   = q_val;
              low_nxt   = '0;
              high_nxt  = q_idx;
              state_nxt = ST_LO;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_LO: begin
        rd_addr   = low_r;
        mid_nxt   = low_r + ((high_r - low_r) >> 1);
        state_nxt = ST_HI;
      end
      ST_HI: begin
        rd_addr = high_r;
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = low_r;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MID;
        end
      end
      ST_MID: begin
        rd_addr = mid_r;
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = high_r;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        rd_addr = mid_r;
        if (rd_data_r == key_r) begin
          found_nxt = 1'b1;
          pos_nxt   = mid_r;
          state_nxt = ST_DONE;
        end else if ((low_r == high_r) || ((rd_data_r > key_r) && (mid_r == low_r))) begin
          found_nxt = 1'b0;
          pos_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (rd_data_r > key_r) begin
          high_nxt  = mid_r - 1'b1;
          state_nxt = ST_LO;
        end else begin
          low_nxt   = mid_r + 1'b1;
          state_nxt = ST_LO;
        end
      end
      ST_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    low_r   <= low_nxt;
    high_r  <= high_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[q_idx] <= q_val;
    end
    rd_data_r <= tbl_mem[rd_addr];
  end

  stbs_fifo #(
    .WIDTH(RW),
    .DEPTH(2)
  ) u_result_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (res_push),
    .wr_data(res_wdata),
    .rd_en  (pop),
    .rd_data(res_rdata),
    .full   (res_full),
    .empty  (empty)
  );

  assign res_head = res_rdata;

endmodule

`default_nettype wire

/* rtl/sorted_table_binary_search.sv */
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of signed words loaded in ascending order, searched for a key by
// binary search; each search returns a found flag and the matching index.
// ----------------------------------------------------------------------------
//  Channel   Ports                                        Transfer when
//  request   push full in_req_type in_entry_index         push && !full
//            in_entry_value in_search_key
//  result    empty pop out_found out_position             pop && !empty
//  config    cfg_we cfg_wdata                             cfg_we
//
// A write is applied in the engine as it leaves the request queue; a search
// makes three reads per halving step, of the low, high and middle entries,
// through the single read port of the table memory. Reset clears the queues
// and the count register; the table is undefined until written and needs no
// clearing pass. Two-entry queues on each side of the engine let requests
// and results stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = 1024
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             push,
  output logic                                  full,
  input  wire logic                             in_req_type,
  input  wire logic [stbs_pkg::IndexW-1:0]      in_entry_index,
  input  wire logic signed [stbs_pkg::KeyW-1:0] in_entry_value,
  input  wire logic signed [stbs_pkg::KeyW-1:0] in_search_key,
  output logic                                  empty,
  input  wire logic                             pop,
  output logic                                  out_found,
  output logic [stbs_pkg::PosW-1:0]             out_position,
  input  wire logic                             cfg_we,
  input  wire logic [stbs_pkg::CountW-1:0]      cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [stbs_pkg::CountW-1:0] cfg_count_r;
  logic                        q_pop, q_empty;
  stbs_pkg::stbs_kind_t        q_kind;
  logic [IDX_W-1:0]            q_idx;
  logic [stbs_pkg::KeyW-1:0]   q_val;
  stbs_pkg::stbs_result_t      res_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_we) begin
      cfg_count_r <= cfg_wdata;
    end
  end

  stbs_front #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_req_type   (in_req_type),
    .in_entry_index(in_entry_index),
    .in_entry_value(in_entry_value),
    .in_search_key (in_search_key),
    .cfg_count     (cfg_count_r),
    .q_pop         (q_pop),
    .q_empty       (q_empty),
    .q_kind        (q_kind),
    .q_idx         (q_idx),
    .q_val         (q_val)
  );

  stbs_back #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_kind  (q_kind),
    .q_idx   (q_idx),
    .q_val   (q_val),
    .pop     (pop),
    .empty   (empty),
    .res_head(res_head)
  );

  assign out_found    = res_head.found;
  assign out_position = res_head.position;

endmodule

`default_nettype wire

/* rtl/stbs_checker.sv */
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks of the sorted table binary search block.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        full,
  input wire logic                        empty,
  input wire logic                        pop,
  input wire logic                        out_found,
  input wire logic [stbs_pkg::PosW-1:0]   out_position
);

  // Both queues come out of reset drained.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("request queue full after reset");

  // A miss always reports index zero.
  a_miss_position: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_found) |-> (out_position == '0))
    else $error("miss reported with a nonzero position");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_found) && $stable(out_position)))
    else $error("waiting result changed before transfer");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_found   (out_found),
  .out_position(out_position)
);

`default_nettype wire
